/* src/bbc_pkg.sv */
// Shared constants for the blob bounding box and centroid block.
// Holds the fixed field widths, the default frame limit and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

    // Default largest frame dimension
    localparam int MAX_DIM_DEF = 1024;

    // Configuration port
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Field widths of the pixel and result items
    localparam int PIX_W   = 8;
    localparam int POS_W   = 10;
    localparam int EXT_W   = 11;
    localparam int CENT_W  = 18;
    localparam int COUNT_W = 21;
    localparam int FRAC_W  = 8;

    // Result packing, lowest field first, padded to whole bytes
    localparam int RES_BITS = 2 * POS_W + 2 * EXT_W + 2 * CENT_W + COUNT_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

endpackage

/* src/blob_bounding_box_centroid.sv */
// Pixel items are accepted back to back while a frame streams in. After the last pixel
// of a frame the centroids come from one restoring divider (QW = log2(MAX_DIM) + 8
// quotient bits) that runs a bit per cycle
// and serves the column centroid, then the row centroid; an empty frame skips it and
// goes straight to the output state. Pixels are not taken until the result enters the output
// register. Synchronous active-low reset sets both frame dimensions to 1024, clears the
// position counters and accumulators and drops any pending result. Depends on bbc_pkg.
`timescale 1ns / 1ps

module blob_bounding_box_centroid
    import bbc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Pixel stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIX_W-1:0]      i_s_axis_tdata,   // pixel_value[7:0]
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // box_left[9:0], box_top[19:10], box_width[30:20], box_height[41:31],
    // centroid_col[59:42], centroid_row[77:60], point_count[98:78], zero pad
    output logic [RES_W-1:0]      o_m_axis_tdata,
    output logic                  o_m_axis_tuser    // frame_empty
);

    // Internal widths that follow from the frame limit
    localparam int CW  = $clog2(MAX_DIM);
    localparam int NW  = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int SW  = CW + NW;
    localparam int QW  = CW + FRAC_W;
    localparam int IW  = $clog2(QW + 1);
    localparam int DW  = (CFG_W > CW + 1) ? CFG_W : CW + 1;
    localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);
    localparam logic [DW-1:0] DIM_ONE = DW'(1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [CFG_W-1:0] r_frame_w;
    logic [CFG_W-1:0] r_frame_h;
    logic [2:0]       r_state;
    logic             r_pass;
    logic [IW-1:0]    r_iter;

    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_row;
    logic [NW-1:0]    r_cnt;
    logic [CW-1:0]    r_min_col;
    logic [CW-1:0]    r_max_col;
    logic [CW-1:0]    r_min_row;
    logic [CW-1:0]    r_max_row;
    logic [SW-1:0]    r_col_sum;
    logic [SW-1:0]    r_row_sum;

    logic [SW-1:0]    r_prod;
    logic [NW-1:0]    r_rem;
    logic [QW-1:0]    r_dvd;
    logic [QW-1:0]    r_cent_col;

    logic             r_out_valid;
    logic [RES_W-1:0] r_out_data;
    logic             r_out_empty;

    logic [DW-1:0]    w_dim;
    logic [DW-1:0]    h_dim;
    logic             s_accept;
    logic             s_fg;
    logic             s_col_end;
    logic             s_last;
    logic             s_restart;
    logic             s_out_free;
    logic [NW-1:0]    n_cnt;
    logic [CW-1:0]    s_min_sel;
    logic [SW-1:0]    s_sum_sel;
    logic [SW-1:0]    s_rest;
    logic [NW+1:0]    s_trial;
    logic             s_qbit;
    logic [RES_W-1:0] s_result;

    // Frame size with zero read as one and large values saturated
    always_comb begin
        w_dim = DW'(r_frame_w);
        h_dim = DW'(r_frame_h);
        if (w_dim == '0) begin
            w_dim = DIM_ONE;
        end else if (w_dim > DIM_MAX) begin
            w_dim = DIM_MAX;
        end
        if (h_dim == '0) begin
            h_dim = DIM_ONE;
        end else if (h_dim > DIM_MAX) begin
            h_dim = DIM_MAX;
        end
    end

    // Pixel acceptance and frame position
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign s_fg      = (i_s_axis_tdata != '0);
    assign s_col_end = (DW'(r_col) + DIM_ONE >= w_dim);
    assign s_last    = s_col_end && (DW'(r_row) + DIM_ONE >= h_dim);
    assign n_cnt     = s_fg ? r_cnt + NW'(1) : r_cnt;
    assign s_out_free = !r_out_valid || i_m_axis_tready;

    // A write to a known register, or a result entering the output register, starts a fresh frame
    assign s_restart = (i_cfg_we && (i_cfg_addr == REG_FRAME_WIDTH ||
                                     i_cfg_addr == REG_FRAME_HEIGHT))
                     || (r_state == S_OUT && s_out_free);

    // Shared multiplier, subtractor and divider inputs
    assign s_min_sel = r_pass ? r_min_row : r_min_col;
    assign s_sum_sel = r_pass ? r_row_sum : r_col_sum;
    assign s_rest    = s_sum_sel - r_prod;
    assign s_trial   = {1'b0, r_rem, r_dvd[QW-1]} - (NW + 2)'(r_cnt);
    assign s_qbit    = !s_trial[NW+1];

    // Result packing; an empty frame gives zero geometry
    always_comb begin
        s_result = '0;
        if (r_cnt != '0) begin
            s_result = RES_W'({COUNT_W'(r_cnt),
                               CENT_W'(r_dvd),
                               CENT_W'(r_cent_col),
                               EXT_W'((CW + 1)'(r_max_row) - (CW + 1)'(r_min_row)
                                      + (CW + 1)'(1)),
                               EXT_W'((CW + 1)'(r_max_col) - (CW + 1)'(r_min_col)
                                      + (CW + 1)'(1)),
                               POS_W'(r_min_row),
                               POS_W'(r_min_col)});
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= CFG_W'(1024);
            r_frame_h <= CFG_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_FRAME_WIDTH:  r_frame_w <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame position and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || s_restart) begin
            r_col     <= '0;
            r_row     <= '0;
            r_cnt     <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
        end else if (s_accept) begin
            if (s_fg) begin
                r_cnt <= n_cnt;
                if (r_cnt == '0 || r_col < r_min_col) r_min_col <= r_col;
                if (r_cnt == '0 || r_col > r_max_col) r_max_col <= r_col;
                if (r_cnt == '0 || r_row < r_min_row) r_min_row <= r_row;
                if (r_cnt == '0 || r_row > r_max_row) r_max_row <= r_row;
                r_col_sum <= r_col_sum + SW'(r_col);
                r_row_sum <= r_row_sum + SW'(r_row);
            end
            if (s_col_end) begin
                r_col <= '0;
                r_row <= r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Sequencer: multiply, subtract, then one quotient bit per cycle, twice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
            r_iter  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept && s_last) begin
                        r_pass  <= 1'b0;
                        r_state <= (n_cnt == '0) ? S_OUT : S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUB;
                S_SUB: begin
                    r_iter  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_iter <= r_iter + IW'(1);
                    if (r_iter == IW'(QW - 1)) begin
                        r_pass  <= 1'b1;
                        r_state <= r_pass ? S_OUT : S_MUL;
                    end
                end
                S_OUT: begin
                    if (s_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Shared arithmetic datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL: r_prod <= SW'(s_min_sel * r_cnt);
            S_SUB: begin
                r_rem <= NW'(s_rest >> CW);
                r_dvd <= {s_rest[CW-1:0], FRAC_W'(0)};
            end
            S_DIV: begin
                r_rem <= s_qbit ? s_trial[NW-1:0] : {r_rem[NW-2:0], r_dvd[QW-1]};
                r_dvd <= {r_dvd[QW-2:0], s_qbit};
                if (!r_pass && r_iter == IW'(QW - 1)) begin
                    r_cent_col <= {r_dvd[QW-2:0], s_qbit};
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && s_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && s_out_free) begin
            r_out_data  <= s_result;
            r_out_empty <= (r_cnt == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_empty;

    // An empty frame carries no geometry
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("empty frame result carries nonzero fields");

    // Sums stay zero until the first foreground pixel
    a_sums_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_col_sum == '0 && r_row_sum == '0))
        else $error("accumulated sums without foreground pixels");

    // Box bounds are ordered once a point was seen
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_min_col <= r_max_col && r_min_row <= r_max_row))
        else $error("bounding box bounds out of order");

    // Divider never runs past its last quotient bit
    a_div_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_iter <= IW'(QW - 1)))
        else $error("divider iteration count overrun");

    // A result is only loaded from the output state
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside the output state");

endmodule
